// File: rtl/spo_pkg.sv
`default_nettype none

package spo_pkg;

    localparam int FREQ_W    = 24;
    localparam int DIGIT_W   = 8;
    localparam int NUM_CELLS = FREQ_W / DIGIT_W;
    localparam int PPH_W     = 34;
    localparam int PROD_W    = FREQ_W + PPH_W;
    localparam int PROD_FRAC = 56;
    localparam int SAMPLE_W  = 12;
    localparam int TERMS     = 12;

    localparam logic [PPH_W-1:0] PPH_RESET   = 34'd5864062015;
    localparam logic [63:0]      HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0]      ROUND_HALF  = 64'd2684354560;
    localparam logic [63:0]      ROUND_DIV   = 64'd5368709120;
    localparam logic [63:0]      OUT_GAIN    = 64'd8192;

    // (2k) * (2k + 1) for series term k
    localparam logic [63:0] TAYLOR_DEN [1:TERMS] = '{
        64'd6,   64'd20,  64'd42,  64'd72,  64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };

    typedef struct packed {
        logic              valid;
        logic              last;
        logic [FREQ_W-1:0] freq;
        logic [PROD_W-1:0] sum;
    } spo_beat_t;

    // 1638.4 * sin(pi/2 * j / 2^qshift), Q30 Taylor series, rounded half up
    function automatic logic [SAMPLE_W-1:0] sine_entry(input int unsigned j,
                                                       input int unsigned qshift);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        v;
        logic [63:0]        r;
        logic signed [63:0] sum;
        x    = (HALF_PI_Q30 * 64'(j)) >> qshift;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        for (int k = 1; k <= TERMS; k++)
        begin
            term = ((term * x2) >> 30) / TAYLOR_DEN[k];
            if ((k & 1) != 0)
            begin
                sum = sum - signed'(term);
            end
            else
            begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0)
        begin
            sum = '0;
        end
        v = unsigned'(sum) * OUT_GAIN;
        r = (v + ROUND_HALF) / ROUND_DIV;
        return SAMPLE_W'(r);
    endfunction

endpackage

`default_nettype wire

// File: rtl/spo_mul_cell.sv
`default_nettype none

module spo_mul_cell #(
    parameter int CELL_IDX = 0
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [spo_pkg::PPH_W-1:0]      pph,
    input  wire spo_pkg::spo_beat_t             beat_in,
    output logic                                stall_up,
    output spo_pkg::spo_beat_t                  beat_out,
    input  wire logic                           stall_down
);
    import spo_pkg::*;

    logic                valid_reg;
    logic                last_reg;
    logic [FREQ_W-1:0]   freq_reg;
    logic [PROD_W-1:0]   sum_reg;
    logic [PROD_W-1:0]   sum_next;
    logic [DIGIT_W-1:0]  digit;
    logic [DIGIT_W+PPH_W-1:0] partial;

    assign digit    = beat_in.freq[DIGIT_W-1:0];
    assign partial  = DIGIT_W'(digit) * pph;
    assign sum_next = beat_in.sum + (PROD_W'(partial) << (DIGIT_W * CELL_IDX));
    assign stall_up = valid_reg && stall_down;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!stall_up)
        begin
            valid_reg <= beat_in.valid;
        end
    end

    // advance the payload only on a real beat
    always_ff @(posedge clk)
    begin
        if (!stall_up && beat_in.valid)
        begin
            last_reg <= beat_in.last;
            freq_reg <= beat_in.freq >> DIGIT_W;
            sum_reg  <= sum_next;
        end
    end

    assign beat_out.valid = valid_reg;
    assign beat_out.last  = last_reg;
    assign beat_out.freq  = freq_reg;
    assign beat_out.sum   = sum_reg;

endmodule

`default_nettype wire

// File: rtl/spo_phase_cell.sv
`default_nettype none

module spo_phase_cell #(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire spo_pkg::spo_beat_t                beat_in,
    output logic                                   stall_up,
    output logic                                   out_valid,
    output logic signed [spo_pkg::SAMPLE_W-1:0]    out_sample,
    output logic                                   out_last,
    input  wire logic                              stall_down
);
    import spo_pkg::*;

    localparam int QTR_BITS = SINE_TABLE_BITS - 2;
    localparam int QTR_N    = 1 << QTR_BITS;
    localparam int ADDR_W   = SINE_TABLE_BITS - 1;

    logic [SAMPLE_W-1:0]        qtr_tbl [QTR_N+1];

    logic                       valid_reg;
    logic [PHASE_BITS-1:0]      phase_acc_reg;
    logic [PHASE_BITS-1:0]      phase_acc_next;
    logic [PHASE_BITS-1:0]      inc;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W-1:0] sample_next;
    logic                       last_reg;
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [1:0]                 quad;
    logic [ADDR_W-1:0]          rem;
    logic [ADDR_W-1:0]          addr;
    logic signed [SAMPLE_W-1:0] mag;

    for (genvar j = 0; j <= QTR_N; j++)
    begin : g_tbl
        assign qtr_tbl[j] = sine_entry(j, QTR_BITS);
    end

    assign inc            = beat_in.sum[PROD_FRAC-1 -: PHASE_BITS];
    assign phase_acc_next = phase_acc_reg + inc;

    assign idx  = phase_acc_reg[PHASE_BITS-1 -: SINE_TABLE_BITS];
    assign quad = idx[SINE_TABLE_BITS-1 -: 2];
    assign rem  = ADDR_W'(idx[QTR_BITS-1:0]);
    assign addr = quad[0] ? (ADDR_W'(QTR_N) - rem) : rem;
    assign mag  = signed'(qtr_tbl[addr]);
    assign sample_next = quad[1] ? -mag : mag;

    assign stall_up = valid_reg && stall_down;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            phase_acc_reg <= '0;
        end
        else if (!stall_up)
        begin
            valid_reg <= beat_in.valid;
            if (beat_in.valid)
            begin
                phase_acc_reg <= phase_acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall_up && beat_in.valid)
        begin
            sample_reg <= sample_next;
            last_reg   <= beat_in.last;
        end
    end

    assign out_valid  = valid_reg;
    assign out_sample = sample_reg;
    assign out_last   = last_reg;

endmodule

`default_nettype wire

// File: rtl/sine_phase_oscillator.sv
// Sine oscillator: one frame beat in, one sample beat out, one frame per clock
// sustained while sample_stall is low. A frame passes a row of three multiplier
// cells, each folding one 8-bit digit of freq_hz times phase_per_hz into a
// running product, and then the phase cell, which looks up the sine of the held
// phase in a quarter-wave constant table, registers the sample, and advances the
// phase by the product. Each of the three digit cells and the phase cell
// registers the frame in turn. Stall stops only full cells, so bubbles close up
// while the output waits. phase_per_hz is 2^48 / sample rate (reset value gives
// 48 kHz); write it only while no frame is in flight.
`default_nettype none

module sine_phase_oscillator #(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [spo_pkg::PPH_W-1:0]         phase_per_hz,
    input  wire logic                              frame_valid,
    output logic                                   frame_stall,
    input  wire logic [spo_pkg::FREQ_W-1:0]        freq_hz,
    input  wire logic                              block_last,
    output logic                                   sample_valid,
    input  wire logic                              sample_stall,
    output logic signed [spo_pkg::SAMPLE_W-1:0]    sample_out,
    output logic                                   block_last_out
);
    import spo_pkg::*;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 12'sd1639;

    logic [PPH_W-1:0] pph_reg;
    spo_beat_t        beat [NUM_CELLS+1];
    logic             stall [NUM_CELLS+1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pph_reg <= PPH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            pph_reg <= phase_per_hz;
        end
    end

    assign beat[0].valid = frame_valid;
    assign beat[0].last  = block_last;
    assign beat[0].freq  = freq_hz;
    assign beat[0].sum   = '0;
    assign frame_stall   = stall[0];

    for (genvar c = 0; c < NUM_CELLS; c++)
    begin : g_cell
        spo_mul_cell #(
            .CELL_IDX (c)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .pph        (pph_reg),
            .beat_in    (beat[c]),
            .stall_up   (stall[c]),
            .beat_out   (beat[c+1]),
            .stall_down (stall[c+1])
        );
    end

    spo_phase_cell #(
        .PHASE_BITS      (PHASE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_phase (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat_in    (beat[NUM_CELLS]),
        .stall_up   (stall[NUM_CELLS]),
        .out_valid  (sample_valid),
        .out_sample (sample_out),
        .out_last   (block_last_out),
        .stall_down (sample_stall)
    );

    a_stall_needs_full_output: assert property (@(posedge clk) disable iff (!rst_n)
        frame_stall |-> (sample_valid && sample_stall))
        else $error("frame stalled while the output can move");

    a_sample_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid |-> (sample_out <= SAMPLE_MAX && sample_out >= -SAMPLE_MAX))
        else $error("sample beyond full scale");

    a_idle_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_valid |-> !frame_stall)
        else $error("frame stalled with an empty output");

endmodule

`default_nettype wire

// File: tb/sv/sine_phase_oscillator_checker.sv
`default_nettype none

module sine_phase_oscillator_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    input  wire logic                                cfg_ready,
    input  wire logic [spo_pkg::PPH_W-1:0]           phase_per_hz,
    input  wire logic                                frame_valid,
    input  wire logic                                frame_stall,
    input  wire logic [spo_pkg::FREQ_W-1:0]          freq_hz,
    input  wire logic                                block_last,
    input  wire logic                                sample_valid,
    input  wire logic                                sample_stall,
    input  wire logic signed [spo_pkg::SAMPLE_W-1:0] sample_out,
    input  wire logic                                block_last_out,
    output int unsigned                              mismatches,
    output int unsigned                              outstanding,
    output int unsigned                              frames_seen,
    output int unsigned                              samples_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import spo_pkg::*;

    localparam int PHASE_BITS = 32;
    localparam int TABLE_BITS = 10;
    localparam int QUARTER    = 1 << (TABLE_BITS - 2);
    localparam int SERIES_LEN = 12;

    typedef logic [63:0] u64_t;

    localparam u64_t HALF_PI_Q30 = 64'd1686629713;
    localparam u64_t GAIN        = 64'd8192;
    localparam u64_t ROUND_ADD   = u64_t'(5) << 29;
    localparam u64_t ROUND_DIV   = u64_t'(5) << 30;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } osc_sample_t;

    logic signed [SAMPLE_W-1:0] sine_quarter [0:QUARTER];
    osc_sample_t                expected_samples [$];
    osc_sample_t                want;
    logic [PPH_W-1:0]           step_per_hz;
    logic [PHASE_BITS-1:0]      osc_phase;
    logic [PROD_W-1:0]          product;
    int unsigned                mismatch_count;
    int unsigned                frame_count;
    int unsigned                sample_count;

    // 1638.4 * sin(pi/2 * j / QUARTER), Q30 series, rounded half up
    function automatic logic signed [SAMPLE_W-1:0] quarter_sine(input int unsigned j);
        u64_t               x;
        u64_t               x2;
        u64_t               term;
        logic signed [63:0] acc;
        int                 k;
        x    = (HALF_PI_Q30 * u64_t'(j)) / u64_t'(QUARTER);
        x2   = (x * x) >> 30;
        term = x;
        acc  = $signed(x);
        for (k = 1; k <= SERIES_LEN; k++)
        begin
            term = ((term * x2) >> 30) / u64_t'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
            begin
                acc = acc - $signed(term);
            end
            else
            begin
                acc = acc + $signed(term);
            end
        end
        if (acc < 0)
        begin
            acc = '0;
        end
        return SAMPLE_W'(($unsigned(acc) * GAIN + ROUND_ADD) / ROUND_DIV);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sine_at_index(
        input logic [TABLE_BITS-1:0] idx
    );
        logic [1:0]                 quad;
        logic [TABLE_BITS-3:0]      offset;
        logic signed [SAMPLE_W-1:0] mag;
        quad   = idx[TABLE_BITS-1 -: 2];
        offset = idx[TABLE_BITS-3:0];
        mag    = quad[0] ? sine_quarter[QUARTER - int'(offset)] : sine_quarter[offset];
        return quad[1] ? -mag : mag;
    endfunction

    initial
    begin : fill_table
        int j;
        for (j = 0; j <= QUARTER; j++)
        begin
            sine_quarter[j] = quarter_sine(j);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_per_hz = PPH_RESET;
            osc_phase   = '0;
            expected_samples.delete();
            mismatch_count = 0;
            frame_count    = 0;
            sample_count   = 0;
            mismatches      <= 0;
            outstanding     <= 0;
            frames_seen     <= 0;
            samples_checked <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                step_per_hz = phase_per_hz;
            end
            if (frame_valid && !frame_stall)
            begin
                expected_samples.push_back('{
                    sample: sine_at_index(osc_phase[PHASE_BITS-1 -: TABLE_BITS]),
                    last:   block_last
                });
                // advance after the sample is taken
                product   = PROD_W'(freq_hz) * PROD_W'(step_per_hz);
                osc_phase = osc_phase + PHASE_BITS'(product >> (PROD_FRAC - PHASE_BITS));
                frame_count++;
            end
            if (sample_valid && !sample_stall)
            begin
                if (expected_samples.size() == 0)
                begin
                    mismatch_count++;
                    $error("sample_out: expected no beat, got %0d", sample_out);
                end
                else
                begin
                    want = expected_samples.pop_front();
                    sample_count++;
                    if (sample_out !== want.sample)
                    begin
                        mismatch_count++;
                        $error("sample_out: expected %0d, got %0d", want.sample, sample_out);
                    end
                    if (block_last_out !== want.last)
                    begin
                        mismatch_count++;
                        $error("block_last_out: expected %0b, got %0b",
                               want.last, block_last_out);
                    end
                end
            end
            mismatches      <= mismatch_count;
            outstanding     <= expected_samples.size();
            frames_seen     <= frame_count;
            samples_checked <= sample_count;
        end
    end

endmodule

`default_nettype wire

// File: tb/sv/sine_phase_oscillator_test.sv
`default_nettype none

module sine_phase_oscillator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import spo_pkg::*;

    localparam int LATENCY     = 4;
    localparam int SETTLE      = 2 * LATENCY;
    localparam int LONG_HOLD   = 120;
    localparam int PHASE_ITEMS = 110;

    localparam logic [PPH_W-1:0] PPH_MAX     = '1;
    localparam logic [PPH_W-1:0] PPH_QUARTER = 34'h1_0000_0000;
    localparam logic [PPH_W-1:0] PPH_UNITY   = 34'h0_0100_0000;

    typedef enum {RX_FLOW, RX_RANDOM, RX_PATTERN, RX_HOLD} rx_mode_t;

    logic                       clk;
    logic                       rst_n        = 1'b0;
    logic                       cfg_valid    = 1'b0;
    logic                       cfg_ready;
    logic [PPH_W-1:0]           phase_per_hz = '0;
    logic                       frame_valid  = 1'b0;
    logic                       frame_stall;
    logic [FREQ_W-1:0]          freq_hz      = '0;
    logic                       block_last   = 1'b0;
    logic                       sample_valid;
    logic                       sample_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       block_last_out;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned frames_seen;
    int unsigned samples_checked;

    int unsigned settings_used = 0;
    int unsigned hold_requests = 0;
    int          burst_left    = 0;
    int          block_left    = 0;
    bit          steady        = 1'b0;

    sine_phase_oscillator dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .phase_per_hz   (phase_per_hz),
        .frame_valid    (frame_valid),
        .frame_stall    (frame_stall),
        .freq_hz        (freq_hz),
        .block_last     (block_last),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .sample_out     (sample_out),
        .block_last_out (block_last_out)
    );

    sine_phase_oscillator_checker sample_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .phase_per_hz    (phase_per_hz),
        .frame_valid     (frame_valid),
        .frame_stall     (frame_stall),
        .freq_hz         (freq_hz),
        .block_last      (block_last),
        .sample_valid    (sample_valid),
        .sample_stall    (sample_stall),
        .sample_out      (sample_out),
        .block_last_out  (block_last_out),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .frames_seen     (frames_seen),
        .samples_checked (samples_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("sine_phase_oscillator regression: fail");
        $finish;
    end

    initial
    begin : receiver
        rx_mode_t    mode;
        int          span;
        int unsigned served;
        logic [7:0]  pattern;
        mode    = RX_FLOW;
        span    = 0;
        served  = 0;
        pattern = '0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != served)
            begin
                served++;
                mode = RX_HOLD;
                span = LONG_HOLD;
            end
            else if (span <= 0)
            begin
                mode    = rx_mode_t'($urandom_range(0, 2));
                span    = $urandom_range(8, 80);
                pattern = 8'($urandom);
            end
            span--;
            pattern = {pattern[6:0], pattern[7]};
            case (mode)
                RX_FLOW:    sample_stall <= 1'b0;
                RX_RANDOM:  sample_stall <= ($urandom_range(0, 99) < 35);
                RX_PATTERN: sample_stall <= pattern[0];
                default:    sample_stall <= 1'b1;
            endcase
        end
    end

    // offer one beat, hold it until taken, then maybe drop valid for a gap
    task automatic send_frame(input logic [FREQ_W-1:0] freq, input logic last);
        int gap;
        frame_valid <= 1'b1;
        freq_hz     <= freq;
        block_last  <= last;
        @(posedge clk);
        while (frame_stall)
        begin
            @(posedge clk);
        end
        if (!steady)
        begin
            if (burst_left <= 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap        = $urandom_range(1, 6);
                frame_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    function automatic logic [FREQ_W-1:0] pick_freq();
        int bin;
        bin = $urandom_range(0, 99);
        if (bin < 45)
        begin
            return FREQ_W'($urandom);
        end
        else if (bin < 60)
        begin
            return FREQ_W'($urandom_range(0, 255));
        end
        else if (bin < 70)
        begin
            return '0;
        end
        else if (bin < 80)
        begin
            return FREQ_W'(24'hFF_FFFF - $urandom_range(0, 3));
        end
        return FREQ_W'(1) << $urandom_range(0, FREQ_W - 1);
    endfunction

    task automatic send_random(input int count);
        int i;
        for (i = 0; i < count; i++)
        begin
            if (block_left <= 0)
            begin
                block_left = $urandom_range(1, 16);
            end
            block_left--;
            send_frame(pick_freq(), block_left == 0);
        end
    endtask

    task automatic settle_phase();
        if (frame_valid)
        begin
            frame_valid <= 1'b0;
        end
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_phase_step(input logic [PPH_W-1:0] value);
        cfg_valid    <= 1'b1;
        phase_per_hz <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic run_setting(input logic [PPH_W-1:0] value, input bit pressure);
        write_phase_step(value);
        if (pressure)
        begin
            steady = 1'b1;
            hold_requests <= hold_requests + 1;
        end
        send_random(PHASE_ITEMS);
        steady = 1'b0;
        settle_phase();
    endtask

    initial
    begin : stimulus
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero frequency under the reset step: phase holds at zero
        send_frame('0, 1'b0);
        send_frame('0, 1'b1);
        send_frame('0, 1'b0);
        settle_phase();

        // quarter-turn step: walk the quadrant boundaries, then alias
        write_phase_step(PPH_QUARTER);
        repeat (5) send_frame(24'h40_0000, 1'b0);
        send_frame(24'h80_0000, 1'b1);
        send_frame(24'h80_0000, 1'b0);
        send_frame(24'hC0_0000, 1'b0);
        send_frame(24'hC0_0000, 1'b1);
        send_frame(24'h10_0000, 1'b0);
        send_frame(24'h10_0000, 1'b0);
        send_frame('0, 1'b0);
        send_frame('0, 1'b1);
        send_frame(24'hFF_FFFF, 1'b0);
        send_frame(24'hFF_FFFF, 1'b1);
        settle_phase();

        // widest product
        write_phase_step(PPH_MAX);
        send_frame(24'hFF_FFFF, 1'b0);
        send_frame(24'hFF_FFFF, 1'b1);
        send_frame(24'h00_0001, 1'b0);
        settle_phase();

        run_setting(PPH_MAX, 1'b0);
        run_setting('0, 1'b0);
        run_setting(PPH_RESET, 1'b0);
        run_setting(PPH_W'(1), 1'b0);
        run_setting(PPH_UNITY, 1'b0);
        run_setting({2'($urandom_range(0, 3)), 32'($urandom)}, 1'b0);
        run_setting(PPH_W'($urandom_range(0, 32'h03FF_FFFF)), 1'b0);
        run_setting(PPH_RESET, 1'b1);

        $display("covered %0d frames, %0d samples checked, %0d phase_per_hz settings",
                 frames_seen, samples_checked, settings_used);
        $display("settings span zero, one and full scale; one long output hold filled the pipe");
        if (mismatches == 0)
        begin
            $display("sine_phase_oscillator regression: pass");
        end
        else
        begin
            $display("sine_phase_oscillator regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
